### src/tlv_response_deframer_defines.svh
// assertion macros for the tlv response deframer
// no dependencies; included by the top level only
`ifndef TLV_RESPONSE_DEFRAMER_DEFINES_SVH
`define TLV_RESPONSE_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

`define TLVRD_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error("tlvrd assertion failed");

`define TLVRD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error("tlvrd assertion failed");

`else

`define TLVRD_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)

`define TLVRD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

### src/tlvrd_pkg.sv
// shared types and constants for the tlv response deframer
// no dependencies; imported by every module of the block
package tlvrd_pkg;

    localparam int CFG_W           = 25;
    localparam int LENGTH_BITS_DEF = 25;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CODE_W          = 32;

    localparam logic [CFG_W-1:0] MAX_FRAME_RESET = CFG_W'(16 * 1024 * 1024);

    localparam logic [7:0] TYPE_OUTPUT = 8'd1;
    localparam logic [7:0] TYPE_DONE   = 8'd2;

    localparam logic [CODE_W-1:0] DONE_LENGTH = CODE_W'(4);

    typedef enum logic [2:0] {
        KIND_BYTE      = 3'd0,
        KIND_EMPTY     = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_OVERSIZED = 3'd3,
        KIND_BAD_DONE  = 3'd4,
        KIND_UNKNOWN   = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              last;
        logic [CODE_W-1:0] data;
    } q_entry_t;

endpackage

### src/tlvrd_front.sv
// front end: accepts stream bytes, tracks frame headers and classifies each byte
// depends on tlvrd_pkg; pushes result records into tlvrd_queue
module tlvrd_front import tlvrd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             q_full,
    output logic             q_push,
    output q_entry_t         q_push_entry
);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LENGTH,
        PH_PAYLOAD
    } phase_t;

    localparam logic [CODE_W:0]   LEN_LIMIT = (CODE_W+1)'(1) << LENGTH_BITS;
    localparam logic [CODE_W-1:0] LEN_MASK  = CODE_W'(LEN_LIMIT - (CODE_W+1)'(1));

    phase_t                 phase_reg, phase_next;
    logic [7:0]             type_reg, type_next;
    logic [1:0]             hdr_cnt_reg, hdr_cnt_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic                   len_four_reg, len_four_next;
    logic [CODE_W-1:0]      acc_reg, acc_next;
    logic                   halted_reg, halted_next;
    logic [CFG_W-1:0]       max_reg, max_next;

    logic                   accept;
    logic [CODE_W-1:0]      acc_shift;
    logic [LENGTH_BITS-1:0] remain_dec;
    logic                   oversized;

    assign s_ready    = !q_full;
    assign cfg_ready  = 1'b1;
    assign accept     = s_valid && s_ready;
    assign acc_shift  = {s_data_byte, acc_reg[CODE_W-1:8]};
    assign remain_dec = remain_reg - LENGTH_BITS'(1);
    assign oversized  = (acc_shift > {{(CODE_W-CFG_W){1'b0}}, max_reg})
                     || (acc_shift > LEN_MASK);

    always_comb begin
        phase_next    = phase_reg;
        type_next     = type_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        remain_next   = remain_reg;
        len_four_next = len_four_reg;
        acc_next      = acc_reg;
        halted_next   = halted_reg;
        max_next      = max_reg;
        q_push        = 1'b0;
        q_push_entry  = '{kind: KIND_BYTE, last: 1'b0, data: '0};

        if (cfg_valid && cfg_ready) begin
            max_next = cfg_data;
        end

        if (accept && !halted_reg) begin
            unique case (phase_reg)
                PH_TYPE: begin
                    type_next    = s_data_byte;
                    hdr_cnt_next = 2'd0;
                    acc_next     = '0;
                    phase_next   = PH_LENGTH;
                end
                PH_LENGTH: begin
                    acc_next     = acc_shift;
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    if (hdr_cnt_reg == 2'd3) begin
                        acc_next      = '0;
                        remain_next   = acc_shift[LENGTH_BITS-1:0];
                        len_four_next = (acc_shift == DONE_LENGTH);
                        if (oversized) begin
                            halted_next       = 1'b1;
                            phase_next        = PH_TYPE;
                            q_push            = 1'b1;
                            q_push_entry.kind = KIND_OVERSIZED;
                        end else if (acc_shift == '0) begin
                            phase_next = PH_TYPE;
                            q_push     = 1'b1;
                            if (type_reg == TYPE_OUTPUT) begin
                                q_push_entry.kind = KIND_EMPTY;
                                q_push_entry.last = 1'b1;
                            end else begin
                                halted_next       = 1'b1;
                                q_push_entry.kind = (type_reg == TYPE_DONE) ?
                                                    KIND_BAD_DONE : KIND_UNKNOWN;
                            end
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    remain_next = remain_dec;
                    if (type_reg == TYPE_OUTPUT) begin
                        q_push            = 1'b1;
                        q_push_entry.kind = KIND_BYTE;
                        q_push_entry.data = {{(CODE_W-8){1'b0}}, s_data_byte};
                        q_push_entry.last = (remain_dec == '0);
                        if (remain_dec == '0) begin
                            phase_next = PH_TYPE;
                        end
                    end else if (type_reg == TYPE_DONE) begin
                        acc_next = acc_shift;
                        if (remain_dec == '0) begin
                            phase_next = PH_TYPE;
                            q_push     = 1'b1;
                            if (len_four_reg) begin
                                acc_next          = '0;
                                q_push_entry.kind = KIND_DONE;
                                q_push_entry.data = acc_shift;
                            end else begin
                                halted_next       = 1'b1;
                                q_push_entry.kind = KIND_BAD_DONE;
                            end
                        end
                    end else if (remain_dec == '0) begin
                        halted_next       = 1'b1;
                        phase_next        = PH_TYPE;
                        q_push            = 1'b1;
                        q_push_entry.kind = KIND_UNKNOWN;
                    end
                end
                default: begin
                    phase_next = PH_TYPE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TYPE;
            type_reg     <= '0;
            hdr_cnt_reg  <= '0;
            remain_reg   <= '0;
            len_four_reg <= 1'b0;
            acc_reg      <= '0;
            halted_reg   <= 1'b0;
            max_reg      <= MAX_FRAME_RESET;
        end else begin
            phase_reg    <= phase_next;
            type_reg     <= type_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            remain_reg   <= remain_next;
            len_four_reg <= len_four_next;
            acc_reg      <= acc_next;
            halted_reg   <= halted_next;
            max_reg      <= max_next;
        end
    end

endmodule

### src/tlvrd_queue.sv
// short result queue between the front end and the output stage
// depends on tlvrd_pkg for the entry type
module tlvrd_queue import tlvrd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output q_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/tlvrd_back.sv
// output stage: pops result records and expands them into the result fields
// depends on tlvrd_pkg; fed by tlvrd_queue
module tlvrd_back import tlvrd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  q_entry_t          q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_kind,
    output logic [7:0]        m_payload_byte,
    output logic              m_last_of_frame,
    output logic [CODE_W-1:0] m_exit_code
);

    logic              valid_reg;
    kind_t             kind_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic [CODE_W-1:0] code_reg;

    assign q_pop = !q_empty && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg <= q_head.kind;
            last_reg <= q_head.last;
            byte_reg <= (q_head.kind == KIND_BYTE) ? q_head.data[7:0] : 8'd0;
            code_reg <= (q_head.kind == KIND_DONE) ? q_head.data : '0;
        end
    end

    assign m_valid         = valid_reg;
    assign m_kind          = kind_reg;
    assign m_payload_byte  = byte_reg;
    assign m_last_of_frame = last_reg;
    assign m_exit_code     = code_reg;

endmodule

### src/tlv_response_deframer.sv
// top level of the tlv response deframer: front end, result queue, output stage
// depends on tlvrd_pkg, tlvrd_front, tlvrd_queue, tlvrd_back and the defines header

// Takes one stream byte per clock while s_ready is high and gives at most one result
// per byte. The front-end state machine decides each byte in the cycle it is accepted,
// and s_ready drops only while the result queue (QUEUE_DEPTH entries) is full.
// Results reach the m_ side through the queue memory and then the output register.
// The user must write the frame size limit on the cfg port only while the stream is
// idle; the block itself does not enforce this. After an error result the block
// drops every byte until reset.
`include "tlv_response_deframer_defines.svh"

module tlv_response_deframer import tlvrd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_kind,
    output logic [7:0]        m_payload_byte,
    output logic              m_last_of_frame,
    output logic [CODE_W-1:0] m_exit_code,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic     q_push;
    q_entry_t q_push_entry;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    q_entry_t q_head;
    logic     push_error;
    logic     out_not_byte;

    tlvrd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_push_entry (q_push_entry)
    );

    tlvrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    tlvrd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_payload_byte  (m_payload_byte),
        .m_last_of_frame (m_last_of_frame),
        .m_exit_code     (m_exit_code)
    );

    assign push_error = q_push && (q_push_entry.kind == KIND_OVERSIZED
                                || q_push_entry.kind == KIND_BAD_DONE
                                || q_push_entry.kind == KIND_UNKNOWN);

    assign out_not_byte = m_valid && (m_kind != KIND_BYTE);

    `TLVRD_ASSERT_IMPLIES(a_push_not_full, aclk, aresetn, q_push, !q_full)
    `TLVRD_ASSERT_IMPLIES(a_pop_not_empty, aclk, aresetn, q_pop, !q_empty)
    `TLVRD_ASSERT_NEXT(a_quiet_after_error, aclk, aresetn, push_error, !q_push)
    `TLVRD_ASSERT_IMPLIES(a_byte_only_payload, aclk, aresetn, out_not_byte, m_payload_byte == 8'd0)

endmodule

### verif/tlv_response_deframer_tb.sv
// self-checking testbench for tlv_response_deframer: byte stream in, deframed items out
// depends on tlvrd_pkg and the block's rtl; holds its own frame predictor and result queue
// directed frames, random well-formed frames under several size limits, then one fatal frame
module tlv_response_deframer_tb;
    import tlvrd_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam logic [31:0] LEN_LIMIT = 32'((64'd1 << LENGTH_BITS_DEF) - 1);

    typedef struct {
        kind_t       kind;
        logic [7:0]  payload;
        logic        last;
        logic [31:0] code;
    } deframe_result_t;

    typedef enum int {
        FAULT_OVERSIZED,
        FAULT_HUGE_LENGTH,
        FAULT_EMPTY_DONE,
        FAULT_SHORT_DONE,
        FAULT_EMPTY_UNKNOWN,
        FAULT_UNKNOWN
    } fault_t;

    class frame_tracker;
        typedef enum logic [1:0] {AWAIT_TYPE, AWAIT_LENGTH, IN_PAYLOAD} stage_t;

        stage_t                     stage;
        logic [7:0]                 frame_type;
        logic [2:0]                 hdr_count;
        logic [LENGTH_BITS_DEF-1:0] frame_len;
        logic [LENGTH_BITS_DEF-1:0] bytes_left;
        logic [CFG_W-1:0]           size_limit;
        logic [31:0]                gather;
        bit                         halted;
        deframe_result_t            due_results[$];
        int                         mismatch_count;

        function new();
            stage          = AWAIT_TYPE;
            frame_type     = '0;
            hdr_count      = '0;
            frame_len      = '0;
            bytes_left     = '0;
            size_limit     = MAX_FRAME_RESET;
            gather         = '0;
            halted         = 1'b0;
            mismatch_count = 0;
        endfunction

        function void push(kind_t k, logic [7:0] pb, logic lst, logic [31:0] code);
            deframe_result_t r;
            r.kind    = k;
            r.payload = pb;
            r.last    = lst;
            r.code    = code;
            due_results.push_back(r);
        endfunction

        function void abort(kind_t k);
            halted = 1'b1;
            stage  = AWAIT_TYPE;
            push(k, 8'h00, 1'b0, 32'h0);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // one accepted stream byte
        function void take_byte(logic [7:0] b);
            logic [31:0] len;
            if (halted)
                return;
            case (stage)
                AWAIT_TYPE: begin
                    frame_type = b;
                    hdr_count  = '0;
                    gather     = '0;
                    stage      = AWAIT_LENGTH;
                end
                AWAIT_LENGTH: begin
                    gather    = {b, gather[31:8]};
                    hdr_count = hdr_count + 3'd1;
                    if (hdr_count == 3'd4) begin
                        len       = gather;
                        gather    = '0;
                        hdr_count = '0;
                        if (len > 32'(size_limit) || len > LEN_LIMIT) begin
                            abort(KIND_OVERSIZED);
                        end else begin
                            frame_len  = len[LENGTH_BITS_DEF-1:0];
                            bytes_left = frame_len;
                            if (frame_len == '0) begin
                                stage = AWAIT_TYPE;
                                if (frame_type == TYPE_OUTPUT)
                                    push(KIND_EMPTY, 8'h00, 1'b1, 32'h0);
                                else if (frame_type == TYPE_DONE)
                                    abort(KIND_BAD_DONE);
                                else
                                    abort(KIND_UNKNOWN);
                            end else begin
                                stage = IN_PAYLOAD;
                            end
                        end
                    end
                end
                IN_PAYLOAD: begin
                    bytes_left = bytes_left - 1'b1;
                    if (frame_type == TYPE_OUTPUT) begin
                        if (bytes_left == '0)
                            stage = AWAIT_TYPE;
                        push(KIND_BYTE, b, bytes_left == '0, 32'h0);
                    end else if (frame_type == TYPE_DONE) begin
                        gather = {b, gather[31:8]};
                        if (bytes_left == '0) begin
                            if (32'(frame_len) != DONE_LENGTH) begin
                                abort(KIND_BAD_DONE);
                            end else begin
                                stage = AWAIT_TYPE;
                                push(KIND_DONE, 8'h00, 1'b0, gather);
                                gather = '0;
                            end
                        end
                    end else if (bytes_left == '0) begin
                        abort(KIND_UNKNOWN);
                    end
                end
                default: ;
            endcase
        endfunction

        task flag_mismatch(string what);
            mismatch_count++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task match_result(kind_t k, logic [7:0] pb, logic lst, logic [31:0] code);
            deframe_result_t want;
            if (due_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected item kind %0d byte %02h", k, pb));
                return;
            end
            want = due_results.pop_front();
            if (k !== want.kind)
                flag_mismatch($sformatf("kind %0d, want %0d", k, want.kind));
            if (pb !== want.payload)
                flag_mismatch($sformatf("payload_byte %02h, want %02h", pb, want.payload));
            if (lst !== want.last)
                flag_mismatch($sformatf("last_of_frame %0b, want %0b", lst, want.last));
            if (code !== want.code)
                flag_mismatch($sformatf("exit_code %08h, want %08h", code, want.code));
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_data_byte;
    logic              m_valid;
    logic              m_ready;
    logic [2:0]        m_kind;
    logic [7:0]        m_payload_byte;
    logic              m_last_of_frame;
    logic [CODE_W-1:0] m_exit_code;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;

    frame_tracker tracker = new();
    int  bytes_sent    = 0;
    int  gap_odds      = 0;
    int  hold_requests = 0;
    bit  quiet         = 1'b0;

    tlv_response_deframer u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_payload_byte  (m_payload_byte),
        .m_last_of_frame (m_last_of_frame),
        .m_exit_code     (m_exit_code),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (bytes_sent % 40 == 0) begin
            case ($urandom_range(0, 2))
                0: gap_odds = 0;
                1: gap_odds = 3;
                default: gap_odds = 10;
            endcase
        end
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            gap = $urandom_range(1, 10);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            send_byte(w[8*i +: 8]);
    endtask

    task automatic send_header(input logic [7:0] ftype, input logic [31:0] flen);
        send_byte(ftype);
        send_word(flen);
    endtask

    task automatic send_frame(input logic [7:0] ftype, input int flen);
        send_header(ftype, 32'(flen));
        for (int i = 0; i < flen; i++)
            send_byte(8'($urandom));
    endtask

    task automatic send_done(input logic [31:0] code);
        send_header(TYPE_DONE, DONE_LENGTH);
        send_word(code);
    endtask

    // stop offering and let every expected item come out
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.size_limit = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_len(input int limit);
        int cap;
        cap = (limit < 12) ? limit : 12;
        if (limit <= 64 && $urandom_range(0, 9) == 0)
            return limit;
        return $urandom_range(0, cap);
    endfunction

    function automatic logic [31:0] pick_code();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_frames(input int limit, input int nbytes);
        int stop;
        stop = bytes_sent + nbytes;
        while (bytes_sent < stop) begin
            if (limit >= 4 && $urandom_range(0, 3) == 0)
                send_done(pick_code());
            else
                send_frame(TYPE_OUTPUT, pick_len(limit));
        end
    endtask

    // one frame that halts the block; limit is at least 9 here
    task automatic send_fault(input int limit);
        fault_t     pick;
        logic [7:0] odd_type;
        int         flen;
        pick     = fault_t'($urandom_range(0, 5));
        odd_type = 8'($urandom_range(3, 255));
        if ($urandom_range(0, 3) == 0)
            odd_type = 8'h00;
        flen = $urandom_range(1, 9);
        if (flen == 4)
            flen = 5;
        case (pick)
            FAULT_OVERSIZED:     send_header(TYPE_OUTPUT, 32'(limit + 1));
            FAULT_HUGE_LENGTH:   send_header(TYPE_DONE,
                                             {8'($urandom_range(2, 255)), 24'($urandom)});
            FAULT_EMPTY_DONE:    send_header(TYPE_DONE, 32'h0);
            FAULT_SHORT_DONE:    send_frame(TYPE_DONE, flen);
            FAULT_EMPTY_UNKNOWN: send_header(odd_type, 32'h0);
            default:             send_frame(odd_type, flen);
        endcase
    endtask

    // result side: random stall bursts plus the long hold-off on request
    initial begin
        int stall_left;
        int hold_seen;
        int window_left;
        int stall_odds;
        stall_left  = 0;
        hold_seen   = 0;
        window_left = 0;
        stall_odds  = 0;
        m_ready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_seen != hold_requests) begin
                hold_seen  = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (window_left == 0) begin
                window_left = 64;
                case ($urandom_range(0, 2))
                    0: stall_odds = 0;
                    1: stall_odds = 4;
                    default: stall_odds = 12;
                endcase
            end
            window_left--;
            if (stall_left == 0 && !quiet && stall_odds != 0
                    && $urandom_range(1, stall_odds) == 1)
                stall_left = $urandom_range(1, 10);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.match_result(kind_t'(m_kind), m_payload_byte, m_last_of_frame, m_exit_code);
    end

    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("** tlv_response_deframer: FAILED **");
        $finish;
    end

    initial begin
        int lim;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = 8'h00;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty frame, byte extremes, exit code all ones
        write_limit(MAX_FRAME_RESET);
        send_frame(TYPE_OUTPUT, 0);
        send_header(TYPE_OUTPUT, 32'd1);
        send_byte(8'hFF);
        send_header(TYPE_OUTPUT, 32'd1);
        send_byte(8'h00);
        send_done(32'hFFFF_FFFF);
        drain_results();

        write_limit('0);
        run_frames(0, 120);
        drain_results();

        write_limit(CFG_W'(1));
        run_frames(1, 150);
        drain_results();

        // receiver holds off while the sender keeps offering
        write_limit(CFG_W'(4));
        hold_requests++;
        run_frames(4, 250);
        drain_results();

        lim = $urandom_range(5, 64);
        write_limit(CFG_W'(lim));
        run_frames(lim, 250);
        drain_results();

        write_limit(MAX_FRAME_RESET);
        run_frames(int'(MAX_FRAME_RESET), 200);
        drain_results();

        // last part without idling, ending in a frame that halts the block
        quiet = 1'b1;
        lim   = $urandom_range(9, 200);
        write_limit(CFG_W'(lim));
        run_frames(lim, 150);
        send_fault(lim);
        drain_results();
        repeat (8) send_byte(8'($urandom));
        drain_results();

        if (tracker.mismatch_count == 0)
            $display("** tlv_response_deframer: PASSED **");
        else
            $display("** tlv_response_deframer: FAILED **");
        $finish;
    end

endmodule
